@@ hdl/mag_heading_hard_iron_cal_assert.svh @@
// Assertion macros for the magnetometer heading block.
`ifndef MAG_HEADING_HARD_IRON_CAL_ASSERT_SVH
`define MAG_HEADING_HARD_IRON_CAL_ASSERT_SVH
// Checks that an antecedent implies a consequent in the next cycle.
`define MHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
// Checks that an antecedent implies a consequent in the same cycle.
`define MHC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`endif

@@ hdl/mhc_pkg.sv @@
// Package with the types and constants of the magnetometer heading block.
package mhc_pkg;
  localparam int TabLen = 24;
  localparam int AccW = 32;
  localparam int VecW = 24;
  localparam logic signed [AccW-1:0] Deg180Fx = 32'sd11796480;
  localparam logic [15:0] HundFull = 16'd36000;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQRT, ST_HRAW, ST_HCAL, ST_OUT
  } state_t;

  // Control between the sequencer and the CORDIC unit.
  typedef struct packed {
    logic start;
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
  } cordic_req_t;

  typedef struct packed {
    logic done;
    logic [15:0] heading;
  } cordic_rsp_t;

  function automatic logic signed [AccW-1:0] ang_tab(input logic [4:0] i);
    logic signed [AccW-1:0] v;
    unique case (i)
      5'd0: v = 32'sd2949120;  5'd1: v = 32'sd1740967; 5'd2: v = 32'sd919879;
      5'd3: v = 32'sd466945;   5'd4: v = 32'sd234379;  5'd5: v = 32'sd117304;
      5'd6: v = 32'sd58666;    5'd7: v = 32'sd29335;   5'd8: v = 32'sd14668;
      5'd9: v = 32'sd7334;     5'd10: v = 32'sd3667;   5'd11: v = 32'sd1833;
      5'd12: v = 32'sd917;     5'd13: v = 32'sd458;    5'd14: v = 32'sd229;
      5'd15: v = 32'sd115;     5'd16: v = 32'sd57;     5'd17: v = 32'sd29;
      5'd18: v = 32'sd14;      5'd19: v = 32'sd7;      5'd20: v = 32'sd4;
      5'd21: v = 32'sd2;       5'd22: v = 32'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage

@@ hdl/mhc_cordic.sv @@
// Iterative CORDIC vectoring unit giving a heading in hundredths of a degree.
module mhc_cordic #(
  parameter int Steps = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mhc_pkg::cordic_req_t req,
  output mhc_pkg::cordic_rsp_t rsp
);
  import mhc_pkg::*;
  // Vector grows by about 1.65 over the pass; two guard bits cover it.
  localparam int WX = VecW + 2;
  localparam int NSteps = (Steps > TabLen) ? TabLen : Steps;
  logic signed [WX-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [AccW-1:0] acc_r, acc_nxt;
  logic [4:0] i_r, i_nxt;
  logic busy_r, busy_nxt, zero_r, zero_nxt, done_r, done_nxt;
  logic signed [AccW+7:0] scaled;
  logic signed [AccW-9:0] h;
  logic signed [AccW-9:0] hw;

  // One rotation step per cycle.
  always_comb begin
    x_nxt = x_r; y_nxt = y_r; acc_nxt = acc_r; i_nxt = i_r;
    busy_nxt = busy_r; zero_nxt = zero_r; done_nxt = 1'b0;
    if (req.start) begin
      zero_nxt = (req.x == '0) && (req.y == '0);
      if (req.x < 0) begin
        x_nxt = -WX'(req.x); y_nxt = -WX'(req.y); acc_nxt = Deg180Fx;
      end else begin
        x_nxt = WX'(req.x); y_nxt = WX'(req.y); acc_nxt = '0;
      end
      i_nxt = '0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (y_r > 0) begin
        x_nxt = x_r + (y_r >>> i_r); y_nxt = y_r - (x_r >>> i_r);
        acc_nxt = acc_r + ang_tab(i_r);
      end else begin
        x_nxt = x_r - (y_r >>> i_r); y_nxt = y_r + (x_r >>> i_r);
        acc_nxt = acc_r - ang_tab(i_r);
      end
      i_nxt = i_r + 5'd1;
      if (i_r == 5'(NSteps - 1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
    x_r <= x_nxt; y_r <= y_nxt; acc_r <= acc_nxt; i_r <= i_nxt; zero_r <= zero_nxt;
  end

  // Scale to hundredths and wrap into one turn.
  always_comb begin
    scaled = (AccW+8)'(acc_r) * 40'sd100 + 40'sd32768;
    h = scaled[AccW+7:16];
    if (h < 0) hw = h + (AccW-8)'(HundFull);
    else if (h >= (AccW-8)'(HundFull)) hw = h - (AccW-8)'(HundFull);
    else hw = h;
    rsp.done = done_r;
    rsp.heading = zero_r ? 16'd0 : hw[15:0];
  end
endmodule

@@ hdl/mhc_isqrt.sv @@
// Iterative integer square root, two bits of the radicand per cycle.
module mhc_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [33:0] n_in,
  output logic        done,
  output logic [15:0] root
);
  logic [33:0] n_r, n_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    n_nxt = n_r; res_nxt = res_r; bit_nxt = bit_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    if (start) begin
      n_nxt = n_in; res_nxt = '0; bit_nxt = 34'h1 << 32; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (n_r >= res_r + bit_r) begin
        n_nxt = n_r - (res_r + bit_r); res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r == 34'h1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
    n_r <= n_nxt; res_r <= res_nxt; bit_r <= bit_nxt;
  end

  assign done = done_r;
  assign root = res_r[15:0];
endmodule

@@ hdl/mag_heading_hard_iron_cal.sv @@
// Top level of the magnetometer heading block with hard-iron calibration.
//
// Input words on in_tdata carry one magnetometer sample; in_tuser is the
// sensor-ready flag. Each accepted word yields exactly one result word on
// out_tdata, with out_tuser as the valid flag.
// A not-ready word gives an all-zero result that is valid in the cycle after
// it is accepted, and it leaves the min/max tracking alone. A ready word
// updates min/max, squares the three axes in turn on one squarer and then
// runs a square root and one or two CORDIC vectoring passes on one shared
// unit. The block takes one word at a time; in_tready is low while it works
// and rises the cycle after the result is taken. The result is held in an
// output register until taken; a stalled receiver holds the block in that
// state. Reset loads min to 32767, max to -32768 and the span threshold to
// 60. cfg_wr_en writes the threshold from cfg_wr_data.
`include "mag_heading_hard_iron_cal_assert.svh"
module mag_heading_hard_iron_cal #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  // Fields from bit 0: mag_x, mag_y, mag_z.
  input  logic [47:0]  in_tdata,
  // Fields from bit 0: sensor_ready.
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // Fields from bit 0: magnitude, heading_raw, heading_cal, cal_applied,
  // span_x, span_y, span_z, then zero fill.
  output logic [103:0] out_tdata,
  // Fields from bit 0: valid_res.
  output logic         out_tuser
);
  import mhc_pkg::*;

  state_t st_r, st_nxt;
  logic [15:0] thr_r;
  logic signed [15:0] xmin_r, xmax_r, ymin_r, ymax_r, zmin_r, zmax_r;
  logic signed [15:0] x_r, y_r, z_r;
  logic [15:0] mag_r, hraw_r, hcal_r;
  logic cal_r, vres_r, ovalid_r;
  logic [33:0] sq_acc_r;
  logic [1:0] ax_r;
  logic sq_go_r;
  logic sq_start, sq_done;
  logic [15:0] sq_root;
  logic signed [15:0] mul_a;
  logic [31:0] mul_p;
  cordic_req_t creq;
  cordic_rsp_t crsp;
  logic [15:0] sx, sy, sz;
  logic signed [16:0] offx, offy;

  mhc_isqrt u_sqrt (.clk, .rst_n, .start(sq_start), .n_in(sq_acc_r),
    .done(sq_done), .root(sq_root));
  mhc_cordic #(.Steps(CORDIC_STEPS)) u_cordic (.clk, .rst_n, .req(creq), .rsp(crsp));

  assign sx = 16'(xmax_r - xmin_r);
  assign sy = 16'(ymax_r - ymin_r);
  assign sz = 16'(zmax_r - zmin_r);
  assign offx = 17'(xmax_r) + 17'(xmin_r);
  assign offy = 17'(ymax_r) + 17'(ymin_r);

  // One shared squarer, one axis per cycle.
  always_comb begin
    unique case (ax_r)
      2'd0: mul_a = x_r;
      2'd1: mul_a = y_r;
      default: mul_a = z_r;
    endcase
    mul_p = 32'(32'(mul_a) * 32'(mul_a));
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (in_tvalid && in_tready) st_nxt = in_tuser ? ST_SQRT : ST_OUT;
      ST_SQRT: if (sq_done) st_nxt = ST_HRAW;
      ST_HRAW: if (crsp.done) st_nxt = cal_r ? ST_HCAL : ST_OUT;
      ST_HCAL: if (crsp.done) st_nxt = ST_OUT;
      ST_OUT: if (ovalid_r && out_tready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_tready = (st_r == ST_IDLE) && !ovalid_r;
    sq_start = sq_go_r;
    creq.start = ((st_r == ST_SQRT) && sq_done) ||
                 ((st_r == ST_HRAW) && crsp.done && cal_r);
    if (st_r == ST_SQRT) begin
      creq.x = VecW'(x_r); creq.y = VecW'(y_r);
    end else begin
      creq.x = VecW'($signed({x_r, 1'b0})) - VecW'(offx);
      creq.y = VecW'($signed({y_r, 1'b0})) - VecW'(offy);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; thr_r <= 16'd60; ovalid_r <= 1'b0; sq_go_r <= 1'b0;
      ax_r <= 2'd3;
      xmin_r <= 16'sh7fff; ymin_r <= 16'sh7fff; zmin_r <= 16'sh7fff;
      xmax_r <= 16'sh8000; ymax_r <= 16'sh8000; zmax_r <= 16'sh8000;
    end else begin
      st_r <= st_nxt;
      sq_go_r <= (ax_r == 2'd2);
      if (cfg_wr_en) thr_r <= cfg_wr_data;
      if (ax_r != 2'd3) begin
        ax_r <= ax_r + 2'd1;
      end
      if (in_tvalid && in_tready && in_tuser) begin
        ax_r <= 2'd0;
        if ($signed(in_tdata[15:0]) < xmin_r) xmin_r <= in_tdata[15:0];
        if ($signed(in_tdata[15:0]) > xmax_r) xmax_r <= in_tdata[15:0];
        if ($signed(in_tdata[31:16]) < ymin_r) ymin_r <= in_tdata[31:16];
        if ($signed(in_tdata[31:16]) > ymax_r) ymax_r <= in_tdata[31:16];
        if ($signed(in_tdata[47:32]) < zmin_r) zmin_r <= in_tdata[47:32];
        if ($signed(in_tdata[47:32]) > zmax_r) zmax_r <= in_tdata[47:32];
      end
      if (st_r != ST_OUT && st_nxt == ST_OUT) ovalid_r <= 1'b1;
      else if (ovalid_r && out_tready) ovalid_r <= 1'b0;
    end
    // Datapath registers.
    if (in_tvalid && in_tready) begin
      x_r <= in_tdata[15:0]; y_r <= in_tdata[31:16]; z_r <= in_tdata[47:32];
      vres_r <= in_tuser; sq_acc_r <= '0;
      mag_r <= '0; hraw_r <= '0; hcal_r <= '0; cal_r <= 1'b0;
    end
    if (ax_r != 2'd3) sq_acc_r <= sq_acc_r + 34'(mul_p);
    if (ax_r == 2'd2) cal_r <= (sx > thr_r) && (sy > thr_r);
    if (st_r == ST_SQRT && sq_done) mag_r <= sq_root;
    if (st_r == ST_HRAW && crsp.done) begin
      hraw_r <= crsp.heading; hcal_r <= crsp.heading;
    end
    if (st_r == ST_HCAL && crsp.done) hcal_r <= crsp.heading;
  end

  assign out_tvalid = ovalid_r;
  assign out_tuser = vres_r;
  assign out_tdata = vres_r ? {7'd0, sz, sy, sx, cal_r, hcal_r, hraw_r, mag_r} : '0;

  `MHC_ASSERT_NOW(a_busy_no_ready, clk, rst_n, st_r != ST_IDLE, !in_tready)
  `MHC_ASSERT_NEXT(a_hold_out, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `MHC_ASSERT_NOW(a_cal_heading, clk, rst_n, out_tvalid && !cal_r, hcal_r == hraw_r)
endmodule

@@ dv/mag_heading_hard_iron_cal_tb.sv @@
// Self-checking testbench for the magnetometer heading block with hard-iron calibration.
module mag_heading_hard_iron_cal_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Output word layout, from the highest bit down.
  typedef struct packed {
    logic [6:0]  fill;
    logic [15:0] span_z;
    logic [15:0] span_y;
    logic [15:0] span_x;
    logic        cal_applied;
    logic [15:0] heading_cal;
    logic [15:0] heading_raw;
    logic [15:0] magnitude;
  } heading_word_t;

  typedef struct packed {
    logic          valid_res;
    heading_word_t word;
  } heading_result_t;

  localparam int Steps = 16;
  localparam int MaxCycles = 2000000;
  localparam int DrainCycles = 200;

  logic         clk;
  logic         rst_n;
  logic         cfg_wr_en;
  logic [15:0]  cfg_wr_data;
  logic         in_tvalid;
  logic         in_tready;
  logic [47:0]  in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [103:0] out_tdata;
  logic         out_tuser;

  mag_heading_hard_iron_cal #(.CORDIC_STEPS(Steps)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  // Predictor state: threshold and per-axis extremes.
  logic [15:0]        threshold_q;
  logic signed [15:0] min_x, max_x, min_y, max_y, min_z, max_z;
  heading_result_t    expected_q[$];
  int                 error_count;
  int                 cycle_count;
  bit                 long_hold;
  int                 hold_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Floor shift for signed values.
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  // CORDIC vectoring heading in hundredths of a degree.
  function automatic logic [15:0] cordic_heading(longint vx, longint vy);
    longint acc, xs, ys, h;
    longint angles[24];
    angles = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
               14668, 7334, 3667, 1833, 917, 458, 229, 115,
               57, 29, 14, 7, 4, 2, 1, 0};
    acc = 0;
    if (vx == 0 && vy == 0) return 16'd0;
    if (vx < 0) begin
      vx = -vx;
      vy = -vy;
      acc = 11796480;
    end
    for (int i = 0; i < Steps && i < 24; i++) begin
      xs = floor_shift(vx, i);
      ys = floor_shift(vy, i);
      if (vy > 0) begin
        vx += ys; vy -= xs; acc += angles[i];
      end else begin
        vx -= ys; vy += xs; acc -= angles[i];
      end
    end
    h = floor_shift(acc * 100 + 32768, 16);
    if (h < 0) h += 36000;
    if (h >= 36000) h -= 36000;
    return h[15:0];
  endfunction

  function automatic longint int_sqrt(longint n);
    longint r;
    r = 0;
    for (longint b = 64'd1 << 40; b != 0; b >>= 2) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
    end
    return r;
  endfunction

  // Computes the expected result of one sample and, for a ready sample, updates the extremes.
  function automatic heading_result_t predict_heading(logic ready, logic [47:0] d);
    heading_result_t    r;
    logic signed [15:0] x, y, z;
    longint             sx, sy, sz;
    r = '0;
    if (!ready) return r;
    x = d[15:0]; y = d[31:16]; z = d[47:32];
    if (x < min_x) min_x = x;
    if (x > max_x) max_x = x;
    if (y < min_y) min_y = y;
    if (y > max_y) max_y = y;
    if (z < min_z) min_z = z;
    if (z > max_z) max_z = z;
    sx = longint'(max_x) - min_x;
    sy = longint'(max_y) - min_y;
    sz = longint'(max_z) - min_z;
    r.valid_res = 1'b1;
    r.word.magnitude = 16'(int_sqrt(longint'(x) * x + longint'(y) * y + longint'(z) * z));
    r.word.heading_raw = cordic_heading(x, y);
    r.word.cal_applied = (sx > threshold_q) && (sy > threshold_q);
    r.word.heading_cal = r.word.cal_applied ?
        cordic_heading(2 * longint'(x) - (longint'(max_x) + min_x),
                       2 * longint'(y) - (longint'(max_y) + min_y)) :
        r.word.heading_raw;
    r.word.span_x = sx[15:0];
    r.word.span_y = sy[15:0];
    r.word.span_z = sz[15:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Sends one word after an optional gap; valid stays high for a following word.
  task automatic send_sample(logic ready, logic [47:0] d, int gap);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    expected_q.push_back(predict_heading(ready, d));
    in_tvalid <= 1'b1;
    in_tuser  <= ready;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_threshold(logic [15:0] v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    threshold_q = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [15:0] random_axis();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  // Directed corners: extremes, zero vector, not-ready words.
  task automatic test_directed();
    send_sample(1'b0, 48'hffff_ffff_ffff, 0);
    send_sample(1'b1, 48'h0, 0);
    send_sample(1'b1, {16'h7fff, 16'h7fff, 16'h7fff}, 0);
    send_sample(1'b1, {16'h8000, 16'h8000, 16'h8000}, 1);
    send_sample(1'b0, 48'h1234_5678_9abc, 0);
    send_sample(1'b1, {16'h0, 16'h0, 16'h8000}, 0);
    send_sample(1'b1, {16'h0, 16'h8000, 16'h7fff}, 2);
    send_sample(1'b1, {16'h0, 16'h0064, 16'h0}, 0);
    send_sample(1'b1, {16'h0, 16'hff9c, 16'hff9c}, 0);
    send_sample(1'b1, {16'h0005, 16'h0001, 16'h0}, 0);
  endtask

  // Threshold extremes: zero allows any nonzero span, the maximum none.
  task automatic test_threshold_extremes();
    write_threshold(16'd0);
    send_sample(1'b1, {16'h0, 16'h0003, 16'hfffd}, 0);
    send_sample(1'b1, {16'h0010, 16'hfff0, 16'h0020}, 0);
    write_threshold(16'hffff);
    send_sample(1'b1, {16'h0, 16'h0100, 16'h0200}, 0);
    write_threshold(16'd60);
  endtask

  // Random traffic in bursts, with threshold changes between phases.
  task automatic test_random(int count);
    int burst;
    for (int n = 0; n < count; n += burst) begin
      burst = $urandom_range(1, 20);
      if ($urandom_range(0, 9) == 0)
        write_threshold($urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 500)));
      for (int k = 0; k < burst; k++)
        send_sample($urandom_range(0, 7) != 0, {random_axis(), random_axis(), random_axis()},
                    $urandom_range(0, 3) == 0 ? $urandom_range(1, 30) : 0);
    end
  endtask

  // Receiver holds off for a long stretch while samples keep coming.
  task automatic test_backpressure();
    long_hold = 1'b1;
    for (int k = 0; k < 6; k++)
      send_sample(1'b1, {random_axis(), random_axis(), random_axis()}, 0);
    wait_drained();
    wait (!long_hold);
  endtask

  // Receiver stall pattern and the long hold-off counted here.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_cycles <= 0;
    end else if (long_hold) begin
      out_tready <= 1'b0;
      if (hold_cycles == 600) begin
        long_hold <= 1'b0;
        hold_cycles <= 0;
      end else begin
        hold_cycles <= hold_cycles + 1;
      end
    end else begin
      out_tready <= (cycle_count % 512 < 128) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    heading_result_t exp_r;
    heading_word_t   got;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected word", out_tuser, 0);
      end else begin
        exp_r = expected_q.pop_front();
        if (out_tuser !== exp_r.valid_res) report_mismatch("valid_res", out_tuser, exp_r.valid_res);
        if (got.magnitude !== exp_r.word.magnitude)
          report_mismatch("magnitude", got.magnitude, exp_r.word.magnitude);
        if (got.heading_raw !== exp_r.word.heading_raw)
          report_mismatch("heading_raw", got.heading_raw, exp_r.word.heading_raw);
        if (got.heading_cal !== exp_r.word.heading_cal)
          report_mismatch("heading_cal", got.heading_cal, exp_r.word.heading_cal);
        if (got.cal_applied !== exp_r.word.cal_applied)
          report_mismatch("cal_applied", got.cal_applied, exp_r.word.cal_applied);
        if (got.span_x !== exp_r.word.span_x) report_mismatch("span_x", got.span_x, exp_r.word.span_x);
        if (got.span_y !== exp_r.word.span_y) report_mismatch("span_y", got.span_y, exp_r.word.span_y);
        if (got.span_z !== exp_r.word.span_z) report_mismatch("span_z", got.span_z, exp_r.word.span_z);
        if (got.fill !== '0) report_mismatch("fill", got.fill, 0);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    if (cycle_count >= MaxCycles) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    long_hold = 1'b0;
    cycle_count = 0;
    error_count = 0;
    threshold_q = 16'd60;
    min_x = 16'sh7fff; min_y = 16'sh7fff; min_z = 16'sh7fff;
    max_x = 16'sh8000; max_y = 16'sh8000; max_z = 16'sh8000;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_threshold_extremes();
    test_backpressure();
    test_random(740);
    wait_drained();
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+hdl
hdl/mhc_pkg.sv
hdl/mhc_cordic.sv
hdl/mhc_isqrt.sv
hdl/mag_heading_hard_iron_cal.sv
dv/mag_heading_hard_iron_cal_tb.sv
